// File: rtl/pvfe_pkg.sv
`timescale 1ns / 1ps
package pvfe_pkg;

    // Field widths fixed by the stream format.
    localparam int DATA_W = 24;
    localparam int BIN_W  = 9;
    localparam int PHASE_W = 16;
    localparam int CFG_W  = 24;
    localparam int FREQ_W = 32;

    // CORDIC datapath: inputs grow by about 2.33 over all rotations.
    localparam int XW = DATA_W + 3;
    localparam int ZW = 32;
    localparam int ATAN_LEN = 24;

    // Inverse CORDIC gain in Q24.
    localparam logic [23:0] INV_GAIN_Q24 = 24'd10188014;

    // Quarter turns as 32-bit and 16-bit binary angles.
    localparam logic [ZW-1:0] Z_QUARTER       = 32'h4000_0000;
    localparam logic [ZW-1:0] Z_THREE_QUARTER = 32'hC000_0000;
    localparam logic [PHASE_W-1:0] PH_QUARTER       = 16'h4000;
    localparam logic [PHASE_W-1:0] PH_THREE_QUARTER = 16'hC000;

    // Configuration register indexes.
    localparam logic CFG_HZ_PER_TURN = 1'b0;
    localparam logic CFG_BIN_SPACING = 1'b1;

    // One CORDIC pipeline stage.
    typedef struct packed {
        logic                 valid;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic [ZW-1:0]        z;
        logic                 re_zero;
        logic                 im_pos;
        logic                 im_neg;
        logic [BIN_W-1:0]     bin;
        logic                 first;
    } t_cstage;

    // Arctangent of 2^-i in 32-bit binary angle units.
    function automatic logic [ZW-1:0] atan_turns(input logic [4:0] idx);
        logic [ZW-1:0] a;
        case (idx)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// File: rtl/pvfe_cordic.sv
`timescale 1ns / 1ps
module pvfe_cordic #(
    parameter int STAGES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [pvfe_pkg::DATA_W-1:0] i_re,
    input  logic signed [pvfe_pkg::DATA_W-1:0] i_im,
    input  logic [pvfe_pkg::BIN_W-1:0]    i_bin,
    input  logic                          i_first,
    output pvfe_pkg::t_cstage             o_stage
);
    import pvfe_pkg::*;

    t_cstage r_st [STAGES+1];
    t_cstage n_st0;
    logic signed [XW-1:0] w_re;
    logic signed [XW-1:0] w_im;

    // Pre-rotation by a quarter turn brings the vector into the right half plane.
    always_comb begin
        w_re = XW'(i_re);
        w_im = XW'(i_im);
        n_st0.valid   = i_valid;
        n_st0.re_zero = (i_re == '0);
        n_st0.im_pos  = (i_im > 0);
        n_st0.im_neg  = i_im[DATA_W-1];
        n_st0.bin     = i_bin;
        n_st0.first   = i_first;
        n_st0.x = w_re;
        n_st0.y = w_im;
        n_st0.z = '0;
        if (i_re[DATA_W-1]) begin
            if (!i_im[DATA_W-1]) begin
                n_st0.x = w_im;
                n_st0.y = -w_re;
                n_st0.z = Z_QUARTER;
            end else begin
                n_st0.x = -w_im;
                n_st0.y = w_re;
                n_st0.z = Z_THREE_QUARTER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st[0].valid <= 1'b0;
        end else if (i_en) begin
            r_st[0] <= n_st0;
        end
    end

    // One micro-rotation per register stage.
    for (genvar k = 0; k < STAGES; k++) begin : g_rot
        t_cstage n_st;
        logic signed [XW-1:0] w_dx;
        logic signed [XW-1:0] w_dy;

        always_comb begin
            w_dx = $signed(r_st[k].x) >>> k;
            w_dy = $signed(r_st[k].y) >>> k;
            n_st = r_st[k];
            if (!r_st[k].y[XW-1]) begin
                n_st.x = r_st[k].x + w_dy;
                n_st.y = r_st[k].y - w_dx;
                n_st.z = r_st[k].z + atan_turns(5'(k));
            end else begin
                n_st.x = r_st[k].x - w_dy;
                n_st.y = r_st[k].y + w_dx;
                n_st.z = r_st[k].z - atan_turns(5'(k));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[k+1].valid <= 1'b0;
            end else if (i_en) begin
                r_st[k+1] <= n_st;
            end
        end
    end

    assign o_stage = r_st[STAGES];

endmodule

// File: rtl/pvfe_phase_track.sv
`timescale 1ns / 1ps
module pvfe_phase_track #(
    parameter int HALF_BINS = 512
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [pvfe_pkg::BIN_W-1:0]     i_bin,
    input  logic [pvfe_pkg::PHASE_W-1:0]   i_phase,
    input  logic                           i_first,
    output logic                           o_clr_busy,
    output logic                           o_valid,
    output logic [pvfe_pkg::BIN_W-1:0]     o_bin,
    output logic signed [pvfe_pkg::PHASE_W-1:0] o_dphi
);
    import pvfe_pkg::*;

    localparam int AW = (HALF_BINS > 1) ? $clog2(HALF_BINS) : 1;

    logic [PHASE_W-1:0] r_mem [HALF_BINS];
    logic [PHASE_W-1:0] r_rd_data;
    logic               r_clr_busy;
    logic [AW-1:0]      r_clr_addr;

    logic               r_m1_valid;
    logic [BIN_W-1:0]   r_m1_bin;
    logic [PHASE_W-1:0] r_m1_phase;
    logic               r_m1_first;

    logic               r_m2_valid;
    logic [BIN_W-1:0]   r_m2_bin;
    logic [PHASE_W-1:0] r_m2_phase;
    logic [PHASE_W-1:0] r_dphi;

    logic [PHASE_W-1:0] n_prev;
    logic [PHASE_W-1:0] n_dphi;

    // Clearing pass over the phase memory after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(HALF_BINS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Phase memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd_data <= r_mem[AW'(i_bin)];
        end
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_en && r_m1_valid) begin
            r_mem[AW'(r_m1_bin)] <= r_m1_phase;
        end
    end

    // The beat one stage ahead wrote its phase on the edge this beat was read.
    always_comb begin
        if (r_m1_first) begin
            n_prev = '0;
        end else if (r_m2_valid && (r_m2_bin == r_m1_bin)) begin
            n_prev = r_m2_phase;
        end else begin
            n_prev = r_rd_data;
        end
        n_dphi = r_m1_phase - n_prev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
            r_m2_valid <= 1'b0;
        end else if (i_en) begin
            r_m1_valid <= i_valid;
            r_m2_valid <= r_m1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1_bin   <= i_bin;
            r_m1_phase <= i_phase;
            r_m1_first <= i_first;
            r_m2_bin   <= r_m1_bin;
            r_m2_phase <= r_m1_phase;
            r_dphi     <= n_dphi;
        end
    end

    assign o_clr_busy = r_clr_busy;
    assign o_valid    = r_m2_valid;
    assign o_bin      = r_m2_bin;
    assign o_dphi     = $signed(r_dphi);

endmodule

// File: rtl/pvfe_freq_calc.sv
`timescale 1ns / 1ps
module pvfe_freq_calc (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [pvfe_pkg::PHASE_W-1:0] i_dphi,
    input  logic [pvfe_pkg::BIN_W-1:0]          i_bin,
    input  logic [pvfe_pkg::DATA_W-1:0]         i_mag,
    input  logic [pvfe_pkg::CFG_W-1:0]          i_hz_per_turn,
    input  logic [pvfe_pkg::CFG_W-1:0]          i_bin_spacing,
    output logic                                o_valid,
    output logic [pvfe_pkg::DATA_W-1:0]         o_mag,
    output logic signed [pvfe_pkg::FREQ_W-1:0]  o_freq,
    output logic [pvfe_pkg::BIN_W-1:0]          o_bin
);
    import pvfe_pkg::*;

    localparam int FP_W = PHASE_W + CFG_W + 1;
    localparam int BP_W = BIN_W + CFG_W;
    localparam int RND_W = FP_W - 16;
    localparam int SUM_W = BP_W + 2;

    logic                    r_m3_valid;
    logic signed [FP_W-1:0]  r_fprod;
    logic [BP_W-1:0]         r_bprod;
    logic [DATA_W-1:0]       r_m3_mag;
    logic [BIN_W-1:0]        r_m3_bin;

    logic                    r_m4_valid;
    logic [DATA_W-1:0]       r_m4_mag;
    logic signed [FREQ_W-1:0] r_m4_freq;
    logic [BIN_W-1:0]        r_m4_bin;

    logic signed [FP_W-1:0]  w_fprod;
    logic signed [FP_W-1:0]  w_rnd_full;
    logic signed [RND_W-1:0] w_rnd;
    logic signed [SUM_W-1:0] w_sum;
    logic signed [FREQ_W-1:0] n_freq;

    // Both products side by side in one stage.
    assign w_fprod = i_dphi * $signed({1'b0, i_hz_per_turn});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fprod  <= w_fprod;
            r_bprod  <= i_bin * i_bin_spacing;
            r_m3_mag <= i_mag;
            r_m3_bin <= i_bin;
        end
    end

    // Round the phase term to nearest, add the bin offset, saturate.
    always_comb begin
        w_rnd_full = r_fprod + FP_W'(32768);
        w_rnd = RND_W'(w_rnd_full >>> 16);
        w_sum = SUM_W'(w_rnd) + $signed({2'b00, r_bprod});
        if (w_sum > $signed(SUM_W'(32'h7FFF_FFFF))) begin
            n_freq = 32'sh7FFF_FFFF;
        end else if (w_sum < -$signed(SUM_W'(33'h0_8000_0000))) begin
            n_freq = 32'sh8000_0000;
        end else begin
            n_freq = FREQ_W'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m4_mag  <= r_m3_mag;
            r_m4_freq <= n_freq;
            r_m4_bin  <= r_m3_bin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3_valid <= 1'b0;
            r_m4_valid <= 1'b0;
        end else if (i_en) begin
            r_m3_valid <= i_valid;
            r_m4_valid <= r_m3_valid;
        end
    end

    assign o_valid = r_m4_valid;
    assign o_mag   = r_m4_mag;
    assign o_freq  = r_m4_freq;
    assign o_bin   = r_m4_bin;

endmodule

// File: rtl/phase_vocoder_bin_freq_estimate.sv
`timescale 1ns / 1ps
// An accepted beat passes the CORDIC registers, phase tracking and frequency calculation.
// Throughput: one beat per cycle unless the output stalls; one rotation stage per CORDIC register sets the depth.
// Bins zero and not below HALF_BINS are taken and give no result.
// Reset is synchronous, active low; it restores both rate registers and then sweeps
// the phase memory to zero, with s_axis_tready low meanwhile.
module phase_vocoder_bin_freq_estimate #(
    parameter int HALF_BINS     = 512,
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Fields from bit 0: bin_real[23:0], bin_imag[47:24], bin_number[56:48], zero fill.
    input  logic [63:0] s_axis_tdata,
    // Fields: first_frame.
    input  logic        s_axis_tuser,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: magnitude[23:0], frequency[55:24], out_bin[64:56], zero fill.
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import pvfe_pkg::*;

    logic [CFG_W-1:0] r_hz_per_turn;
    logic [CFG_W-1:0] r_bin_spacing;

    logic             w_en;
    logic             w_clr_busy;
    logic             w_in_valid;
    logic [BIN_W-1:0] w_in_bin;
    t_cstage          w_cout;

    logic [XW-2:0]        w_xpos;
    logic [PHASE_W-1:0]   w_phase;
    logic [XW+23:0]       r_mag_prod;
    logic [XW+23:0]       w_mag_rnd;
    logic [DATA_W-1:0]    r_mag;
    logic [XW-1:0]        w_mag_q;

    logic                 w_pt_valid;
    logic [BIN_W-1:0]     w_pt_bin;
    logic signed [PHASE_W-1:0] w_dphi;

    logic                 w_out_valid;
    logic [DATA_W-1:0]    w_out_mag;
    logic signed [FREQ_W-1:0] w_out_freq;
    logic [BIN_W-1:0]     w_out_bin;

    // Rate registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hz_per_turn <= CFG_W'(22050);
            r_bin_spacing <= CFG_W'(11025);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HZ_PER_TURN: r_hz_per_turn <= i_cfg_data;
                CFG_BIN_SPACING: r_bin_spacing <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline advances unless a result waits at the output.
    assign w_en          = !w_out_valid || m_axis_tready;
    assign s_axis_tready = w_en && !w_clr_busy;
    assign w_in_bin      = s_axis_tdata[56:48];
    assign w_in_valid    = s_axis_tvalid && s_axis_tready && (w_in_bin != '0)
                           && (32'(w_in_bin) < HALF_BINS);

    pvfe_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_in_valid),
        .i_re    ($signed(s_axis_tdata[23:0])),
        .i_im    ($signed(s_axis_tdata[47:24])),
        .i_bin   (w_in_bin),
        .i_first (s_axis_tuser),
        .o_stage (w_cout)
    );

    // Phase from the accumulated angle; a zero real part gives an exact axis.
    always_comb begin
        if (w_cout.re_zero) begin
            if (w_cout.im_pos) begin
                w_phase = PH_QUARTER;
            end else if (w_cout.im_neg) begin
                w_phase = PH_THREE_QUARTER;
            end else begin
                w_phase = '0;
            end
        end else begin
            w_phase = PHASE_W'((w_cout.z + 32'h0000_8000) >> 16);
        end
    end

    // Magnitude: gain correction product, then rounding and saturation.
    assign w_xpos    = w_cout.x[XW-1] ? '0 : w_cout.x[XW-2:0];
    assign w_mag_rnd = r_mag_prod + (XW+24)'(24'h80_0000);
    assign w_mag_q   = XW'(w_mag_rnd >> 24);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mag_prod <= w_xpos * INV_GAIN_Q24;
            if (w_mag_q > XW'(24'hFF_FFFF)) begin
                r_mag <= 24'hFF_FFFF;
            end else begin
                r_mag <= DATA_W'(w_mag_q);
            end
        end
    end

    pvfe_phase_track #(
        .HALF_BINS (HALF_BINS)
    ) u_phase_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (w_cout.valid),
        .i_bin      (w_cout.bin),
        .i_phase    (w_phase),
        .i_first    (w_cout.first),
        .o_clr_busy (w_clr_busy),
        .o_valid    (w_pt_valid),
        .o_bin      (w_pt_bin),
        .o_dphi     (w_dphi)
    );

    pvfe_freq_calc u_freq_calc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (w_pt_valid),
        .i_dphi        (w_dphi),
        .i_bin         (w_pt_bin),
        .i_mag         (r_mag),
        .i_hz_per_turn (r_hz_per_turn),
        .i_bin_spacing (r_bin_spacing),
        .o_valid       (w_out_valid),
        .o_mag         (w_out_mag),
        .o_freq        (w_out_freq),
        .o_bin         (w_out_bin)
    );

    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tdata  = {7'b0, w_out_bin, w_out_freq, w_out_mag};

endmodule

// File: tb/pvfe_checker.sv
`timescale 1ns / 1ps
module pvfe_checker #(
    parameter int HALF_BINS     = 512,
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [63:0] i_in_data,
    input  logic        i_in_user,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [71:0] i_out_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [23:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);
    import pvfe_pkg::*;

    typedef struct packed {
        logic [23:0] mag;
        logic [31:0] freq;
        logic [8:0]  bin;
    } t_bin_result;

    // Arctangent table in 32-bit binary angle units, one entry per micro-rotation.
    localparam logic [31:0] ATAN_TBL [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

    logic [23:0] rate_per_turn, rate_per_bin;
    logic [15:0] last_phase [HALF_BINS];
    t_bin_result expected_results[$];

    // Vectoring rotation: magnitude and 16-bit phase of one bin.
    function automatic void rotate_bin(input longint re, input longint im,
                                       output logic [23:0] mag, output logic [15:0] ph);
        longint x, y, t, m;
        logic [31:0] z;
        int n;
        x = re; y = im; z = '0;
        if (re < 0) begin
            if (im >= 0) begin
                t = x; x = y; y = -t; z = Z_QUARTER;
            end else begin
                t = x; x = -y; y = t; z = Z_THREE_QUARTER;
            end
        end
        n = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
        for (int i = 0; i < n; i++) begin
            longint dx, dy;
            dx = y >>> i; dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += ATAN_TBL[i];
            end else begin
                x -= dx; y += dy; z -= ATAN_TBL[i];
            end
        end
        if (x < 0) x = 0;
        m = (x * 64'sd10188014 + (64'sd1 <<< 23)) >>> 24;
        if (m > 64'sh FFFFFF) m = 64'hFFFFFF;
        mag = m[23:0];
        if (re == 0)
            ph = (im > 0) ? PH_QUARTER : ((im < 0) ? PH_THREE_QUARTER : 16'h0);
        else
            ph = 16'((z + 32'h8000) >> 16);
    endfunction

    // Predict on accepted input beats; compare on accepted output beats.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rate_per_turn <= 24'd22050;
            rate_per_bin  <= 24'd11025;
            for (int b = 0; b < HALF_BINS; b++) last_phase[b] = '0;
            expected_results.delete();
            o_errors  <= 0;
            o_results <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_HZ_PER_TURN) rate_per_turn <= i_cfg_data;
                else rate_per_bin <= i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                longint re, im, dphi, f;
                logic [23:0] mag;
                logic [15:0] ph, prev, diff;
                int b;
                t_bin_result r;
                re = longint'($signed(i_in_data[23:0]));
                im = longint'($signed(i_in_data[47:24]));
                b = int'(i_in_data[56:48]);
                if (b != 0 && b < HALF_BINS) begin
                    rotate_bin(re, im, mag, ph);
                    prev = i_in_user ? 16'h0 : last_phase[b];
                    last_phase[b] = ph;
                    diff = ph - prev;
                    dphi = longint'($signed(diff));
                    f = ((dphi * longint'(rate_per_turn) + 32768) >>> 16)
                        + longint'(b) * longint'(rate_per_bin);
                    if (f > 64'sd2147483647) f = 64'sd2147483647;
                    if (f < -64'sd2147483648) f = -64'sd2147483648;
                    r.mag = mag; r.freq = f[31:0]; r.bin = b[8:0];
                    expected_results = {expected_results, r};
                end
            end
            if (i_out_valid && i_out_ready) begin
                t_bin_result got, exp_r;
                got.mag = i_out_data[23:0];
                got.freq = i_out_data[55:24];
                got.bin = i_out_data[64:56];
                o_results <= o_results + 1;
                if (expected_results.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected result beat: mag %0d freq %0d bin %0d",
                                 got.mag, $signed(got.freq), got.bin);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        if (o_errors < 10)
                            $display("bin result differs: exp mag %0d freq %0d bin %0d,",
                                     exp_r.mag, $signed(exp_r.freq), exp_r.bin,
                                     " got mag %0d freq %0d bin %0d",
                                     got.mag, $signed(got.freq), got.bin);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= expected_results.size();
        end
    end
endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import pvfe_pkg::*;

    localparam int LATENCY = 16 + 4;
    localparam int WATCHDOG = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [23:0] i_cfg_data = '0;
    int          errors, pending, results;
    int          idle_cycles = 0;
    int          rx_wait = 0;
    bit          hold_off = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    phase_vocoder_bin_freq_estimate dut (.*);

    pvfe_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_data(s_axis_tdata), .i_in_user(s_axis_tuser),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results));

    // Receiver: after each taken beat it waits a random number of cycles,
    // none while in a fast phase.
    bit fast_phase = 1'b0;
    always @(posedge i_clk) begin
        if (hold_off || !i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            rx_wait = fast_phase ? 0 : $urandom_range(0, 7);
            m_axis_tready <= (rx_wait == 0);
        end else if (rx_wait != 0) begin
            rx_wait = rx_wait - 1;
            m_axis_tready <= (rx_wait == 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("phase_vocoder_bin_freq_estimate: mismatch");
            $finish;
        end
    end

    // Sends one bin beat after a random gap and waits for its acceptance.
    task automatic send_bin(input logic [23:0] re, input logic [23:0] im,
                            input logic [8:0] bin, input logic first);
        int gap;
        gap = fast_phase ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {7'b0, bin, im, re};
        s_axis_tuser  <= first;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic end_burst();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // One register write; the task drops the write enable again before anything else drives the port.
    task automatic write_reg(input logic idx, input logic [23:0] val);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random bin: mostly plausible spectra over few bins, some extremes and the ignored bin zero.
    task automatic random_bin();
        logic [23:0] re, im;
        logic [8:0] bin;
        case ($urandom_range(0, 9))
            0: begin re = 24'($urandom); im = 24'($urandom); end
            1: begin
                re = 24'h800000 | 24'($urandom_range(0, 3));
                im = 24'($urandom);
            end
            2: begin re = '0; im = 24'($urandom); end
            default: begin
                re = 24'($urandom_range(0, 8191) - 4096);
                im = 24'($urandom_range(0, 8191) - 4096);
            end
        endcase
        case ($urandom_range(0, 19))
            0: bin = 9'd0;
            1: bin = 9'd511;
            default: bin = 9'($urandom_range(1, 12));
        endcase
        send_bin(re, im, bin, $urandom_range(0, 15) == 0);
    endtask

    logic [23:0] hz_set[5] = '{24'd22050, 24'hFFFFFF, 24'd0, 24'd1, 24'd300000};
    logic [23:0] sp_set[5] = '{24'd11025, 24'hFFFFFF, 24'd0, 24'd7, 24'd4000};

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Directed: axes, extremes of each field, first frame, the ignored bin zero.
        send_bin(24'd1000, 24'd0, 9'd1, 1'b0);
        send_bin(24'd0, 24'd1000, 9'd1, 1'b0);
        send_bin(24'd0, 24'hFFFC18, 9'd1, 1'b0);
        send_bin(24'd0, 24'd0, 9'd2, 1'b0);
        send_bin(24'h7FFFFF, 24'h7FFFFF, 9'd511, 1'b0);
        send_bin(24'h800000, 24'h800000, 9'd511, 1'b0);
        send_bin(24'h800000, 24'h7FFFFF, 9'd3, 1'b1);
        send_bin(24'h7FFFFF, 24'h800000, 9'd3, 1'b0);
        send_bin(24'hFFFFFF, 24'd0, 9'd4, 1'b0);
        send_bin(24'hFFFFFF, 24'hFFFFFF, 9'd4, 1'b1);
        send_bin(24'h123456, 24'h654321, 9'd0, 1'b0);
        send_bin(24'h5A5A5A, 24'hA5A5A5, 9'd256, 1'b1);
        send_bin(24'hA5A5A5, 24'h5A5A5A, 9'd256, 1'b0);
        end_burst();
        // Random phases across register settings, extremes included.
        for (int p = 0; p < 5; p++) begin
            write_reg(CFG_HZ_PER_TURN, hz_set[p]);
            write_reg(CFG_BIN_SPACING, sp_set[p]);
            fast_phase = (p == 3);
            for (int k = 0; k < 330; k++) begin
                if (p == 2 && k == 100) begin
                    // Long receiver hold-off so the pipeline fills and backs up.
                    hold_off <= 1'b1;
                    fork
                        begin
                            repeat (200) @(posedge i_clk);
                            hold_off <= 1'b0;
                        end
                    join_none
                end
                random_bin();
            end
            end_burst();
        end
        if (errors == 0 && pending == 0) begin
            $display("Covered %0d result beats over five rate settings,", results);
            $display("including axis phases, field extremes, first frames and a long stall.");
            $display("phase_vocoder_bin_freq_estimate: match");
        end else begin
            $display("%0d errors, %0d results missing", errors, pending);
            $display("phase_vocoder_bin_freq_estimate: mismatch");
        end
        $finish;
    end
endmodule
